/* rtl/address_pool_allocator_assert.svh */
// Assertion macros for the address pool allocator.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the using module.
`ifndef ADDRESS_POOL_ALLOCATOR_ASSERT_SVH
`define ADDRESS_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define APA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("address pool allocator: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define APA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("address pool allocator: next-cycle check failed");

`endif

/* rtl/apa_pkg.sv */
// Shared constants and types of the address pool allocator.
// Used by apa_row_find and address_pool_allocator; depends on nothing.
package apa_pkg;

  // Default number of host bits below the network prefix.
  localparam int HOST_BITS = 8;

  // One memory row holds eight 2-bit slot codes.
  localparam int COL_BITS  = 3;
  localparam int ROW_SLOTS = 1 << COL_BITS;
  localparam int ROW_W     = 2 * ROW_SLOTS;

  // Slot status codes.
  localparam logic [1:0] SLOT_FREE  = 2'd0;
  localparam logic [1:0] SLOT_ALLOC = 2'd1;
  localparam logic [1:0] SLOT_REUSE = 2'd2;

  // Request kinds.
  localparam logic [1:0] KIND_CLAIM   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_NEXT    = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST   = 2'd2;

  // Result of a search over one memory row.
  typedef struct packed {
    logic                hit;
    logic [COL_BITS-1:0] col;
  } find_t;

endpackage

/* rtl/address_pool_allocator.sv */
// Top level of the address pool allocator: slot status memory, request
// sequencer and configuration registers. Depends on apa_pkg, apa_row_find
// and address_pool_allocator_assert.svh.
//
// Usage:
//   A request (kind_i, address_i) is taken at a clock edge where start_i is
//   high and busy_o is low. Its single result appears on ok_o and granted_o,
//   marked by done_o for exactly one cycle; the receiver cannot stall, so
//   every result is a transfer in the cycle it is shown.
//   Configuration is a separate valid/ready channel (cfg_index_i, cfg_data_i)
//   that is always ready; write it only while the block is idle.
//   Slot status lives in a memory of rows of eight 2-bit codes, read through a
//   registered port, modified and written back. Only one request is in
//   flight, so a write always lands before the next read of any row.
// Sequence: claim or release reads the addressed row, then answers and
//   writes back the changed slot. Unused kind, or next with nothing to give,
//   answers without a memory access. Next searches one memory row at a time,
//   first the rows from row 0 up to the lowest reuse entry (while reuse entries
//   are counted), then, if none is found, the rows from the cursor onward.
// Reset: a clearing pass writes every row to free, one row at a time,
//   with busy_o high; configuration writes are taken.
module address_pool_allocator #(
  parameter int HOST_BITS = apa_pkg::HOST_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    kind_i,
  input  logic [31:0]                   address_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [31:0]                   granted_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [apa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [23:0]                   cfg_data_i
);

  localparam int ColBits   = apa_pkg::COL_BITS;
  localparam int RowW      = apa_pkg::ROW_W;
  localparam int RowBits   = HOST_BITS - ColBits;
  localparam int Rows      = 1 << RowBits;
  localparam int SlotCount = 1 << HOST_BITS;
  localparam int CurW      = ((HOST_BITS > 8) ? HOST_BITS : 8) + 1;
  localparam int CntW      = HOST_BITS + 1;
  localparam int PfxW      = 32 - HOST_BITS;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOK   = 5'b00100,
    ST_REUSE  = 5'b01000,
    ST_CURSOR = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [RowBits-1:0]  clr_q, clr_d;
  logic [RowBits-1:0]  row_q, row_d;
  logic [CurW-1:0]     cursor_q, cursor_d;
  logic [CntW-1:0]     reuse_cnt_q, reuse_cnt_d;
  logic [1:0]          kind_q;
  logic [31:0]         addr_q;
  logic [23:0]         net_prefix_q;
  logic [7:0]          range_first_q, range_last_q;
  logic                done_q, done_d;
  logic                ok_q, ok_d;
  logic [31:0]         granted_q, granted_d;

  // Slot status memory and its ports.
  logic [RowW-1:0]     mem_q [Rows];
  logic [RowW-1:0]     mem_rdata_q;
  logic                mem_re, mem_we;
  logic [RowBits-1:0]  mem_raddr, mem_waddr;
  logic [RowW-1:0]     mem_wdata;
  logic [ColBits-1:0]  set_col;
  logic [1:0]          set_val;

  logic                cfg_we;
  logic [31:0]         pfx_full;
  logic [PfxW-1:0]     pfx;
  logic [CurW-1:0]     host_ext, rl_ext;
  logic                addr_match;
  logic [1:0]          look_slot;
  logic                cur_avail, last_row_same, miss_avail;
  logic [ColBits-1:0]  hi_col;
  logic [CurW-1:0]     nxt_row_start, miss_next;
  logic [RowBits-1:0]  cur_row;
  logic                search_reuse;
  apa_pkg::find_t      find;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign granted_o   = granted_q;

  // Address matching against prefix and host range.
  assign pfx_full   = 32'(net_prefix_q);
  assign pfx        = pfx_full[PfxW-1:0];
  assign host_ext   = CurW'(addr_q[HOST_BITS-1:0]);
  assign rl_ext     = CurW'(range_last_q);
  assign addr_match = (addr_q[31:HOST_BITS] == pfx) &&
                      (host_ext >= CurW'(range_first_q)) && (host_ext <= rl_ext);
  assign look_slot  = mem_rdata_q[{addr_q[ColBits-1:0], 1'b0} +: 2];

  // Cursor bookkeeping: the cursor is in use while it sits at or below the
  // range end and inside the slot space.
  assign cur_row       = cursor_q[HOST_BITS-1:ColBits];
  assign cur_avail     = (cursor_q <= rl_ext) && (cursor_q < CurW'(SlotCount));
  assign last_row_same = (rl_ext[CurW-1:ColBits] == cursor_q[CurW-1:ColBits]);
  assign hi_col        = last_row_same ? rl_ext[ColBits-1:0] : '1;
  assign nxt_row_start = {cursor_q[CurW-1:ColBits] + 1'b1, {ColBits{1'b0}}};
  assign miss_next     = last_row_same ? (rl_ext + 1'b1) : nxt_row_start;
  assign miss_avail    = (miss_next <= rl_ext) && (miss_next < CurW'(SlotCount));

  // Row search, shared by the reuse scan and the cursor scan.
  assign search_reuse = (state_q == ST_REUSE);

  apa_row_find u_find (
    .row_i   (mem_rdata_q),
    .reuse_i (search_reuse),
    .lo_i    (search_reuse ? '0 : cursor_q[ColBits-1:0]),
    .hi_i    (search_reuse ? '1 : hi_col),
    .find_o  (find)
  );

  // Request sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    row_d       = row_q;
    cursor_d    = cursor_q;
    reuse_cnt_d = reuse_cnt_q;
    done_d      = 1'b0;
    ok_d        = ok_q;
    granted_d   = granted_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    set_col     = '0;
    set_val     = apa_pkg::SLOT_ALLOC;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            apa_pkg::KIND_CLAIM, apa_pkg::KIND_RELEASE: begin
              mem_re    = 1'b1;
              mem_raddr = address_i[HOST_BITS-1:ColBits];
              state_d   = ST_LOOK;
            end
            apa_pkg::KIND_NEXT: begin
              if (reuse_cnt_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                row_d     = '0;
                state_d   = ST_REUSE;
              end else if (cur_avail) begin
                mem_re    = 1'b1;
                mem_raddr = cur_row;
                state_d   = ST_CURSOR;
              end else begin
                done_d    = 1'b1;
                ok_d      = 1'b0;
                granted_d = '0;
              end
            end
            default: begin
              done_d    = 1'b1;
              ok_d      = 1'b0;
              granted_d = '0;
            end
          endcase
        end
      end
      ST_LOOK: begin
        done_d    = 1'b1;
        granted_d = '0;
        mem_waddr = addr_q[HOST_BITS-1:ColBits];
        set_col   = addr_q[ColBits-1:0];
        state_d   = ST_IDLE;
        if (kind_q == apa_pkg::KIND_CLAIM) begin
          ok_d = 1'b0;
          if (addr_match && ((look_slot == apa_pkg::SLOT_REUSE) ||
                             (look_slot == apa_pkg::SLOT_FREE))) begin
            ok_d    = 1'b1;
            mem_we  = 1'b1;
            set_val = apa_pkg::SLOT_ALLOC;
            if ((look_slot == apa_pkg::SLOT_REUSE) && (reuse_cnt_q != '0)) begin
              reuse_cnt_d = reuse_cnt_q - 1'b1;
            end
          end
        end else begin
          ok_d = 1'b1;
          if (addr_match && (look_slot == apa_pkg::SLOT_ALLOC)) begin
            mem_we      = 1'b1;
            set_val     = apa_pkg::SLOT_REUSE;
            reuse_cnt_d = reuse_cnt_q + 1'b1;
          end
        end
      end
      ST_REUSE: begin
        if (find.hit) begin
          mem_we      = 1'b1;
          mem_waddr   = row_q;
          set_col     = find.col;
          reuse_cnt_d = reuse_cnt_q - 1'b1;
          done_d      = 1'b1;
          ok_d        = 1'b1;
          granted_d   = {pfx, row_q, find.col};
          state_d     = ST_IDLE;
        end else if (row_q == '1) begin
          // No reuse entry despite a nonzero count: drop the count.
          reuse_cnt_d = '0;
          if (cur_avail) begin
            mem_re    = 1'b1;
            mem_raddr = cur_row;
            state_d   = ST_CURSOR;
          end else begin
            done_d    = 1'b1;
            ok_d      = 1'b0;
            granted_d = '0;
            state_d   = ST_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = row_q + 1'b1;
          row_d     = row_q + 1'b1;
        end
      end
      ST_CURSOR: begin
        if (find.hit) begin
          mem_we    = 1'b1;
          mem_waddr = cur_row;
          set_col   = find.col;
          cursor_d  = CurW'({cur_row, find.col}) + 1'b1;
          done_d    = 1'b1;
          ok_d      = 1'b1;
          granted_d = {pfx, cur_row, find.col};
          state_d   = ST_IDLE;
        end else begin
          cursor_d = miss_next;
          if (miss_avail) begin
            mem_re    = 1'b1;
            mem_raddr = miss_next[HOST_BITS-1:ColBits];
          end else begin
            done_d    = 1'b1;
            ok_d      = 1'b0;
            granted_d = '0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Writing range_first also moves the cursor.
    if (cfg_we && (cfg_index_i == apa_pkg::REG_FIRST)) begin
      cursor_d = CurW'(cfg_data_i[7:0]);
    end
  end

  // Write data: the clearing pass writes free rows, otherwise one slot of
  // the row just read is replaced.
  always_comb begin
    mem_wdata = mem_rdata_q;
    mem_wdata[{set_col, 1'b0} +: 2] = set_val;
    if (state_q == ST_CLEAR) begin
      mem_wdata = '0;
    end
  end

  // Slot status memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      row_q         <= '0;
      cursor_q      <= '0;
      reuse_cnt_q   <= '0;
      done_q        <= 1'b0;
      net_prefix_q  <= '0;
      range_first_q <= '0;
      range_last_q  <= 8'hFF;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      row_q       <= row_d;
      cursor_q    <= cursor_d;
      reuse_cnt_q <= reuse_cnt_d;
      done_q      <= done_d;
      if (cfg_we) begin
        unique case (cfg_index_i)
          apa_pkg::REG_PREFIX: net_prefix_q  <= cfg_data_i;
          apa_pkg::REG_FIRST:  range_first_q <= cfg_data_i[7:0];
          apa_pkg::REG_LAST:   range_last_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      kind_q <= kind_i;
      addr_q <= address_i;
    end
    ok_q      <= ok_d;
    granted_q <= granted_d;
  end

  // Checks on the sequencer.
`include "address_pool_allocator_assert.svh"

  `APA_ASSERT_NEXT(a_accept_leads_on, start_i && !busy_o, done_o || busy_o)
  `APA_ASSERT_NOW(a_done_after_work, done_o, $past(busy_o) || $past(start_i))
  `APA_ASSERT_NOW(a_fail_grants_zero, done_o && !ok_o, granted_o == '0)
  `APA_ASSERT_NOW(a_reuse_bounded, 1'b1, reuse_cnt_q <= CntW'(SlotCount))

endmodule

/* rtl/apa_row_find.sv */
// Find-first search over one memory row of slot codes.
// Depends on apa_pkg for the row geometry, slot codes and the find_t result.
module apa_row_find (
  input  logic [apa_pkg::ROW_W-1:0]    row_i,
  input  logic                         reuse_i,
  input  logic [apa_pkg::COL_BITS-1:0] lo_i,
  input  logic [apa_pkg::COL_BITS-1:0] hi_i,
  output apa_pkg::find_t               find_o
);

  localparam int ColBits = apa_pkg::COL_BITS;

  // Lowest column in lo_i..hi_i that holds a reuse entry (reuse_i) or a
  // slot that is not allocated (cursor search).
  always_comb begin
    logic [ColBits-1:0] jc;
    logic [1:0]         slot;
    logic               want;
    find_o = '0;
    for (int j = apa_pkg::ROW_SLOTS - 1; j >= 0; j--) begin
      jc   = ColBits'(j);
      slot = row_i[2*j +: 2];
      want = reuse_i ? (slot == apa_pkg::SLOT_REUSE) : (slot != apa_pkg::SLOT_ALLOC);
      if (want && (jc >= lo_i) && (jc <= hi_i)) begin
        find_o.hit = 1'b1;
        find_o.col = jc;
      end
    end
  end

endmodule
